// File: rtl/ppm_pkg.sv
// shared types and constants of the perspective point map
package ppm_pkg;

   localparam int CoefW  = 48;
   localparam int CoordW = 32;
   localparam int MagW   = 80;
   localparam int SumW   = 82;
   localparam int RemW   = 81;
   localparam int QuoW   = 32;
   localparam int NumCoef = 8;
   localparam int IdxW   = 4;
   localparam int QDepth = 8;
   localparam int QPtrW  = 3;
   localparam int QCntW  = 4;
   localparam int DivSteps = 32;

   // register indexes
   localparam logic [IdxW-1:0] RegXx = 4'd0;
   localparam logic [IdxW-1:0] RegXy = 4'd1;
   localparam logic [IdxW-1:0] RegX0 = 4'd2;
   localparam logic [IdxW-1:0] RegYx = 4'd3;
   localparam logic [IdxW-1:0] RegYy = 4'd4;
   localparam logic [IdxW-1:0] RegY0 = 4'd5;
   localparam logic [IdxW-1:0] RegPx = 4'd6;
   localparam logic [IdxW-1:0] RegPy = 4'd7;

   typedef logic [NumCoef-1:0][CoefW-1:0] coef_set_type;

   typedef struct packed {
      logic [MagW-1:0] nx_mag;
      logic [MagW-1:0] ny_mag;
      logic [MagW-1:0] d_mag;
      logic            nx_neg;
      logic            ny_neg;
      logic            d_neg;
      logic            dz;
   } job_type;

   typedef struct packed {
      logic [RemW-1:0] rem;
      logic [QuoW-1:0] low;
      logic [QuoW-1:0] quo;
      logic            ovf;
      logic            num_neg;
   } div_lane_type;

   typedef struct packed {
      logic [MagW-1:0] d;
      logic            d_neg;
      logic            dz;
      div_lane_type    lx;
      div_lane_type    ly;
   } div_stage_type;

endpackage

// File: rtl/ppm_front.sv
// front pipeline: products, sums and zero-denominator classification
module ppm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [31:0]           src_x,
   input  logic [31:0]           src_y,
   input  ppm_pkg::coef_set_type coefs,
   output logic                  out_valid,
   output ppm_pkg::job_type      job
);

   logic [4:0]  v_ff, v_in;
   logic [31:0] x1_ff, y1_ff;

   logic [5:0][47:0] cm;
   logic [5:0][31:0] xm;
   logic [5:0]       pneg_in, pneg_ff;
   logic [5:0][55:0] plo_in, plo_ff, phi_in, phi_ff;
   logic [5:0][79:0] prod;
   logic signed [81:0] ps_in [6];
   logic signed [81:0] ps_ff [6];
   logic signed [81:0] den_in, den_ff, nx_in, nx_ff, ny_in, ny_ff;
   logic signed [81:0] c0x, c0y;
   ppm_pkg::job_type job_in, job_ff;
   logic [81:0] abs_d, abs_x, abs_y;

   always_comb begin
      v_in = {v_ff[3:0], in_valid};
      for (int i = 0; i < 6; i++) begin
         logic [47:0] c;
         logic [31:0] s;
         c = coefs[(i == 0) ? ppm_pkg::RegXx : (i == 1) ? ppm_pkg::RegXy :
                   (i == 2) ? ppm_pkg::RegYx : (i == 3) ? ppm_pkg::RegYy :
                   (i == 4) ? ppm_pkg::RegPx : ppm_pkg::RegPy];
         s = (i % 2 == 1) ? y1_ff : x1_ff;
         cm[i] = c[47] ? (~c + 48'd1) : c;
         xm[i] = s[31] ? (~s + 32'd1) : s;
         pneg_in[i] = c[47] ^ s[31];
         plo_in[i] = cm[i][23:0] * xm[i];
         phi_in[i] = cm[i][47:24] * xm[i];
      end
      for (int i = 0; i < 6; i++) begin
         prod[i] = {phi_ff[i], 24'd0} + {24'd0, plo_ff[i]};
         ps_in[i] = pneg_ff[i] ? -$signed({2'b00, prod[i]}) : $signed({2'b00, prod[i]});
      end
      c0x = $signed({{18{coefs[ppm_pkg::RegX0][47]}}, coefs[ppm_pkg::RegX0], 16'd0});
      c0y = $signed({{18{coefs[ppm_pkg::RegY0][47]}}, coefs[ppm_pkg::RegY0], 16'd0});
      den_in = ps_ff[4] + ps_ff[5] + $signed(82'd1 << 48);
      nx_in  = ps_ff[0] + ps_ff[1] + c0x;
      ny_in  = ps_ff[2] + ps_ff[3] + c0y;
      abs_d = den_ff[81] ? -den_ff : den_ff;
      abs_x = nx_ff[81] ? -nx_ff : nx_ff;
      abs_y = ny_ff[81] ? -ny_ff : ny_ff;
      job_in.d_mag  = abs_d[79:0];
      job_in.nx_mag = abs_x[79:0];
      job_in.ny_mag = abs_y[79:0];
      job_in.d_neg  = den_ff[81];
      job_in.nx_neg = nx_ff[81];
      job_in.ny_neg = ny_ff[81];
      job_in.dz     = (den_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      x1_ff   <= src_x;
      y1_ff   <= src_y;
      pneg_ff <= pneg_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      ps_ff   <= ps_in;
      den_ff  <= den_in;
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      job_ff  <= job_in;
   end

   assign out_valid = v_ff[4];
   assign job       = job_ff;

endmodule

// File: rtl/ppm_queue.sv
// short fifo between front and back
module ppm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ppm_pkg::job_type push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic             full,
   output ppm_pkg::job_type head
);

   ppm_pkg::job_type mem [ppm_pkg::QDepth];
   logic [ppm_pkg::QPtrW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [ppm_pkg::QCntW-1:0] cnt_ff, cnt_in;
   logic do_pop;

   always_comb begin
      do_pop = pop && (cnt_ff != '0);
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + ppm_pkg::QCntW'(push) - ppm_pkg::QCntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wp_ff] <= push_data;
      end
   end

   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == ppm_pkg::QCntW'(ppm_pkg::QDepth));
   assign head      = mem[rp_ff];

endmodule

// File: rtl/ppm_back.sv
// back pipeline: one restoring division step per stage, then saturation
module ppm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ppm_pkg::job_type job,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [31:0]      dst_x,
   output logic [31:0]      dst_y,
   output logic             div_zero,
   output logic             clipped
);

   localparam int NS = ppm_pkg::DivSteps;

   ppm_pkg::div_stage_type st_ff [NS+1];
   ppm_pkg::div_stage_type st_in [NS+1];
   logic [NS:0] v_ff;
   logic        en;
   logic        ov_ff;
   logic [31:0] dx_ff, dy_ff, dx_in, dy_in;
   logic        dz_ff, cl_ff, cl_in, cx, cy;

   function automatic ppm_pkg::div_lane_type load_lane(logic [79:0] mag, logic [79:0] d,
                                                       logic neg);
      ppm_pkg::div_lane_type l;
      l.rem     = {17'd0, mag[79:16]};
      l.ovf     = ({16'd0, mag[79:16]} >= d);
      l.low     = {mag[15:0], 16'd0};
      l.quo     = '0;
      l.num_neg = neg;
      return l;
   endfunction

   function automatic ppm_pkg::div_lane_type step_lane(ppm_pkg::div_lane_type l,
                                                       logic [79:0] d);
      ppm_pkg::div_lane_type o;
      logic [80:0] t;
      o = l;
      t = {l.rem[79:0], l.low[31]};
      o.low = {l.low[30:0], 1'b0};
      if (t >= {1'b0, d}) begin
         o.rem = t - {1'b0, d};
         o.quo = {l.quo[30:0], 1'b1};
      end else begin
         o.rem = t;
         o.quo = {l.quo[30:0], 1'b0};
      end
      return o;
   endfunction

   function automatic logic [32:0] finish(ppm_pkg::div_lane_type l, logic d_neg, logic dz);
      logic [32:0] r;
      if (dz) begin
         r = {1'b1, l.num_neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
      end else if (l.num_neg != d_neg) begin
         if (l.ovf || l.quo > 32'h8000_0000) r = {1'b1, 32'h8000_0000};
         else r = {1'b0, 32'd0 - l.quo};
      end else begin
         if (l.ovf || l.quo[31]) r = {1'b1, 32'h7FFF_FFFF};
         else r = {1'b0, l.quo};
      end
      return r;
   endfunction

   assign en       = !ov_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      st_in[0].d     = job.d_mag;
      st_in[0].d_neg = job.d_neg;
      st_in[0].dz    = job.dz;
      st_in[0].lx    = load_lane(job.nx_mag, job.d_mag, job.nx_neg);
      st_in[0].ly    = load_lane(job.ny_mag, job.d_mag, job.ny_neg);
      for (int k = 1; k <= NS; k++) begin
         st_in[k]    = st_ff[k-1];
         st_in[k].lx = step_lane(st_ff[k-1].lx, st_ff[k-1].d);
         st_in[k].ly = step_lane(st_ff[k-1].ly, st_ff[k-1].d);
      end
      {cx, dx_in} = finish(st_ff[NS].lx, st_ff[NS].d_neg, st_ff[NS].dz);
      {cy, dy_in} = finish(st_ff[NS].ly, st_ff[NS].d_neg, st_ff[NS].dz);
      cl_in = cx || cy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v_ff  <= {v_ff[NS-1:0], in_valid};
         ov_ff <= v_ff[NS];
      end
      if (en) begin
         for (int k = 0; k <= NS; k++) begin
            st_ff[k] <= st_in[k];
         end
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= st_ff[NS].dz;
         cl_ff <= cl_in;
      end
   end

   assign out_valid = ov_ff;
   assign dst_x     = dx_ff;
   assign dst_y     = dy_ff;
   assign div_zero  = dz_ff;
   assign clipped   = cl_ff;

endmodule

// File: rtl/perspective_point_map.sv
// top level of the perspective point map
//   channel  dir  handshake          payload
//   req      in   tvalid / tready    tdata: src_x, src_y
//   rsp      out  tvalid / tready    tdata: dst_x, dst_y; tuser: div_zero, clipped
//   csr      in   wen                index, 48-bit wdata
// one item per cycle sustained while results are taken; 5 front stages, queue, 32 division
// steps of the back pipeline plus entry and saturation stages
// synchronous reset clears all coefficients to zero and empties both pipelines
// the back pipeline halts as a whole while a result waits; the front keeps taking
// items while fewer than 8 sit in the front stages and the queue together
module perspective_point_map (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // src_x, src_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // dst_x, dst_y
   output logic [1:0]  rsp_tuser,   // div_zero, clipped
   input  logic        csr_wen,
   input  logic [3:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   ppm_pkg::coef_set_type coef_ff;
   logic [ppm_pkg::QCntW-1:0] cnt_ff, cnt_in;
   logic accept, f_valid, q_ne, q_full, b_ready, pop;
   ppm_pkg::job_type f_job, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            ppm_pkg::RegXx, ppm_pkg::RegXy, ppm_pkg::RegX0, ppm_pkg::RegYx,
            ppm_pkg::RegYy, ppm_pkg::RegY0, ppm_pkg::RegPx, ppm_pkg::RegPy: begin
               coef_ff[csr_index[2:0]] <= csr_wdata;
            end
            default: ;
         endcase
      end
   end

   // credits cover items in the front stages and in the queue
   assign accept     = req_tvalid && req_tready;
   assign pop        = q_ne && b_ready;
   assign req_tready = (cnt_ff != ppm_pkg::QCntW'(ppm_pkg::QDepth));
   assign cnt_in     = cnt_ff + ppm_pkg::QCntW'(accept) - ppm_pkg::QCntW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   ppm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .src_x     (req_tdata[31:0]),
      .src_y     (req_tdata[63:32]),
      .coefs     (coef_ff),
      .out_valid (f_valid),
      .job       (f_job)
   );

   ppm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (f_job),
      .pop       (b_ready),
      .not_empty (q_ne),
      .full      (q_full),
      .head      (q_head)
   );

   ppm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_ne),
      .job       (q_head),
      .in_ready  (b_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .dst_x     (rsp_tdata[31:0]),
      .dst_y     (rsp_tdata[63:32]),
      .div_zero  (rsp_tuser[0]),
      .clipped   (rsp_tuser[1])
   );

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ppm_pkg::QCntW'(ppm_pkg::QDepth))
      else $error("credit count beyond queue depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      f_valid |-> !q_full || pop)
      else $error("push into full queue");

   a_dz_clips: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tuser[1])
      else $error("zero denominator without clip flag");

endmodule

// File: bench/ppm_checker.sv
// checker for the perspective point map: predicts each mapped point and compares results
`timescale 1ns / 100ps
module ppm_checker
   import ppm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // src_x, src_y
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // dst_x, dst_y
   input  logic [1:0]  rsp_tuser,   // div_zero, clipped
   input  logic        csr_wen,
   input  logic [3:0]  csr_index,
   input  logic [47:0] csr_wdata,
   output int          errors,
   output int          pending
);

   typedef struct {
      logic [31:0] dst_x;
      logic [31:0] dst_y;
      logic        div_zero;
      logic        clipped;
   } mapped_point_type;

   logic signed [CoefW-1:0] coef [NumCoef];
   mapped_point_type points_due [$];

   assign pending = points_due.size();

   // sign-magnitude quotient, truncated, saturated to q16.16; bit 32 marks a clip
   function automatic logic [32:0] divide_sat(logic signed [127:0] num,
                                              logic signed [127:0] den);
      logic [127:0] nm, dm, q;
      logic         neg;
      nm  = (num < 0) ? -num : num;
      dm  = (den < 0) ? -den : den;
      neg = (num < 0) != (den < 0);
      q   = (nm << 16) / dm;
      if (neg) begin
         if (q > 128'h8000_0000) return {1'b1, 32'h8000_0000};
         return {1'b0, 32'(-q)};
      end
      if (q > 128'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
      return {1'b0, q[31:0]};
   endfunction

   function automatic mapped_point_type map_point(logic signed [31:0] sx,
                                                  logic signed [31:0] sy);
      logic signed [127:0] x, y, den, nx, ny;
      logic signed [127:0] c [NumCoef];
      logic [32:0]         rx, ry;
      mapped_point_type    r;
      x = sx;
      y = sy;
      for (int i = 0; i < NumCoef; i++) c[i] = coef[i];
      den = c[RegPx] * x + c[RegPy] * y + (128'sd1 <<< 48);
      nx  = c[RegXx] * x + c[RegXy] * y + (c[RegX0] <<< 16);
      ny  = c[RegYx] * x + c[RegYy] * y + (c[RegY0] <<< 16);
      if (den == 0) begin
         r.dst_x    = (nx < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         r.dst_y    = (ny < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         r.div_zero = 1'b1;
         r.clipped  = 1'b1;
      end else begin
         rx = divide_sat(nx, den);
         ry = divide_sat(ny, den);
         r.dst_x    = rx[31:0];
         r.dst_y    = ry[31:0];
         r.div_zero = 1'b0;
         r.clipped  = rx[32] | ry[32];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      mapped_point_type e;
      if (reset) begin
         for (int i = 0; i < NumCoef; i++) coef[i] <= '0;
         points_due.delete();
      end else begin
         if (csr_wen && csr_index < NumCoef) coef[csr_index] <= csr_wdata;
         if (req_tvalid && req_tready)
            points_due.push_back(map_point(req_tdata[31:0], req_tdata[63:32]));
         if (rsp_tvalid && rsp_tready) begin
            if (points_due.size() == 0) begin
               $display("%0t: result with no item outstanding: %h %b", $time, rsp_tdata,
                        rsp_tuser);
               errors++;
            end else begin
               e = points_due.pop_front();
               if (rsp_tdata[31:0] !== e.dst_x) begin
                  $display("%0t: dst_x expected %h actual %h", $time, e.dst_x, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[63:32] !== e.dst_y) begin
                  $display("%0t: dst_y expected %h actual %h", $time, e.dst_y,
                           rsp_tdata[63:32]);
                  errors++;
               end
               if (rsp_tuser[0] !== e.div_zero) begin
                  $display("%0t: div_zero expected %b actual %b", $time, e.div_zero,
                           rsp_tuser[0]);
                  errors++;
               end
               if (rsp_tuser[1] !== e.clipped) begin
                  $display("%0t: clipped expected %b actual %b", $time, e.clipped,
                           rsp_tuser[1]);
                  errors++;
               end
            end
         end
      end
   end

   initial errors = 0;

endmodule

// File: bench/tb_top.sv
// top of the perspective point map bench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
   import ppm_pkg::*;

   localparam logic [IdxW-1:0] RegUnused = 4'd8;
   localparam logic [IdxW-1:0] RegSpare  = 4'd15;
   localparam logic [47:0] One  = 48'h0001_0000_0000;
   localparam logic [47:0] CMax = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] CMin = 48'h8000_0000_0000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // src_x, src_y
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;        // dst_x, dst_y
   logic [1:0]  rsp_tuser;        // div_zero, clipped
   logic        csr_wen = 0;
   logic [3:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;
   int          errors, pending;
   int          send_idle_pct = 0, recv_stall_pct = 0;
   bit          held_once = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   perspective_point_map u_dut (.*);

   ppm_checker u_checker (.*);

   // receiver; one long hold-off once six items are outstanding, so the block backs up
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!held_once && send_idle_pct == 0 && recv_stall_pct == 0 && pending >= 6) begin
            held_once = 1;
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_point(logic [31:0] x, logic [31:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_coefs(logic [47:0] c [NumCoef]);
      for (int i = 0; i < NumCoef; i++) begin
         csr_wen   <= 1;
         csr_index <= i[3:0];
         csr_wdata <= c[i];
         @(posedge clock);
      end
      csr_wen <= 0;
   endtask

   function automatic logic [47:0] rand_coef(int kind);
      case (kind)
         0: return 48'($signed($urandom_range(2 * 65536)) - 65536) <<< 16;
         1: return 48'({$urandom, $urandom});
         2: return ($urandom_range(1)) ? CMax : CMin;
         default: return 48'($signed($urandom_range(65536)) - 32768);
      endcase
   endfunction

   function automatic logic [31:0] rand_coord;
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
         2: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      endcase
   endfunction

   initial begin
      logic [47:0] c [NumCoef];
      logic [31:0] edge_pts [6];
      int kind;
      edge_pts = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h0001_0000, 32'hFFFF_0000};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset coefficients map everything to zero
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h1234_5678, 32'hDEAD_BEEF);
      drain();

      // identity: extremes pass through, minus two to the 31 without a clip
      c = '{One, 48'h0, 48'h0, 48'h0, One, 48'h0, 48'h0, 48'h0};
      write_coefs(c);
      csr_wen <= 1; csr_index <= RegUnused; csr_wdata <= CMax;
      @(posedge clock);
      csr_wen <= 1; csr_index <= RegSpare; csr_wdata <= CMin;
      @(posedge clock);
      csr_wen <= 0;
      for (int i = 0; i < 6; i++) send_point(edge_pts[i], edge_pts[5 - i]);
      drain();

      // zero denominator at x = 1.0, numerators of both signs
      c = '{One, CMin, 48'h0, CMin, One, 48'h0, -One, 48'h0};
      write_coefs(c);
      send_point(32'h0001_0000, 32'h0);
      send_point(32'h0001_0000, 32'h0001_0000);
      send_point(32'h0001_0000, 32'hFFFF_0000);
      drain();

      // overflow both ways
      c = '{CMax, 48'h0, CMax, 48'h0, CMin, CMin, 48'h0, 48'h0};
      write_coefs(c);
      for (int i = 0; i < 6; i++) send_point(edge_pts[i], edge_pts[i]);
      send_point(32'h0000_0001, 32'hFFFF_FFFF);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         for (int set = 0; set < 6; set++) begin
            kind = (set + ph) % 4;
            for (int i = 0; i < NumCoef; i++)
               c[i] = rand_coef(($urandom_range(3) == 0) ? $urandom_range(3) : kind);
            // mostly mild perspective so quotients stay in range
            if (kind == 0) begin
               c[RegPx] = 48'($signed($urandom_range(512)) - 256);
               c[RegPy] = 48'($signed($urandom_range(512)) - 256);
            end
            write_coefs(c);
            for (int n = 0; n < 75; n++) send_point(rand_coord(), rand_coord());
            drain();
         end
      end

      if (errors == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #4ms;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
